// ----- sv/pcc_pkg.sv -----
// Shared types, register map and reset values of the clamped PID controller.
`default_nettype none

package pcc_pkg;

    // One control step as it enters the block.
    typedef struct packed {
        logic signed [15:0] error_deg;
        logic [15:0]        interval;
        logic               clear;
    } step_item_t;

    // One control output.
    typedef struct packed {
        logic signed [15:0] drive;
        logic               saturated;
    } result_item_t;

    // Register port geometry: six 32-bit word registers.
    localparam int APB_AW = 5;
    localparam int APB_DW = 32;

    typedef logic [2:0] reg_idx_t;

    localparam reg_idx_t REG_GAIN_P       = 3'd0;
    localparam reg_idx_t REG_GAIN_I       = 3'd1;
    localparam reg_idx_t REG_GAIN_D       = 3'd2;
    localparam reg_idx_t REG_INT_BOUND    = 3'd3;
    localparam reg_idx_t REG_DRIVE_BOUND  = 3'd4;
    localparam reg_idx_t REG_MIN_INTERVAL = 3'd5;

    localparam logic [15:0] GAIN_P_RST       = 16'd90;
    localparam logic [15:0] GAIN_I_RST       = 16'd5;
    localparam logic [15:0] GAIN_D_RST       = 16'd20;
    localparam logic [14:0] INT_BOUND_RST    = 15'd12800;
    localparam logic [14:0] DRIVE_BOUND_RST  = 15'd2560;
    localparam logic [15:0] MIN_INTERVAL_RST = 16'd66;

endpackage

`default_nettype wire

// ----- sv/pid_controller_clamped_core.sv -----
// Clamped fixed-point PID controller built on a bit-serial multiplier and divider.
`default_nettype none

// Channel  Dir  Handshake                   Payload
// -------  ---  --------------------------  --------------------------------
// step     in   step_valid / step_ready     pcc_pkg::step_item_t (error, dt, clear)
// result   out  result_valid / result_ready pcc_pkg::result_item_t (drive, saturated)
// config   in   APB psel/penable/pwrite     six registers at byte address 4*index
//
// A normal item makes four passes through the shared shift-add multiplier, and
// the restoring divider for the derivative term runs alongside the later
// multiplications. The next item can be accepted as soon as the result of the
// last one is valid.
// A clear item goes straight to the done state and produces a zero result.
// Reset restores the register defaults and zeroes the integral and the last error.
// The result register holds a finished item while the consumer stalls, and a new
// item can already be accepted and worked on behind it.

module pid_controller_clamped_core (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          step_valid,
    output logic                         step_ready,
    input  pcc_pkg::step_item_t          step_data,
    output logic                         result_valid,
    input  wire                          result_ready,
    output pcc_pkg::result_item_t        result_data,
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire [pcc_pkg::APB_AW-1:0]    paddr,
    input  wire [pcc_pkg::APB_DW-1:0]    pwdata,
    output logic [pcc_pkg::APB_DW-1:0]   prdata,
    output logic                         pready
);

    import pcc_pkg::*;

    // Sequencer states.
    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_MD    = 4'd1;   // gain_d * (e - last_error)
    localparam logic [3:0] ST_DIVGO = 4'd2;   // launch the divider
    localparam logic [3:0] ST_MED   = 4'd3;   // e * dt
    localparam logic [3:0] ST_ACC   = 4'd4;   // integral + e * dt
    localparam logic [3:0] ST_CLAMP = 4'd5;   // clamp the integral
    localparam logic [3:0] ST_MP    = 4'd6;   // gain_p * e
    localparam logic [3:0] ST_PSAVE = 4'd7;
    localparam logic [3:0] ST_MI    = 4'd8;   // gain_i * integral
    localparam logic [3:0] ST_ISUM  = 4'd9;
    localparam logic [3:0] ST_WAIT  = 4'd10;  // fold in the derivative quotient
    localparam logic [3:0] ST_RND   = 4'd11;
    localparam logic [3:0] ST_DONE  = 4'd12;

    localparam logic [3:0] MUL_LAST  = 4'd15;
    localparam logic [5:0] DIV_LAST  = 6'd46;
    localparam logic [49:0] RND_HALF = 50'd128;

    // Configuration registers.
    logic signed [15:0] gain_p_reg, gain_p_next;
    logic signed [15:0] gain_i_reg, gain_i_next;
    logic signed [15:0] gain_d_reg, gain_d_next;
    logic [14:0]        int_bound_reg, int_bound_next;
    logic [14:0]        drv_bound_reg, drv_bound_next;
    logic [15:0]        min_int_reg, min_int_next;

    // Controller state.
    logic signed [31:0] integral_reg, integral_next;
    logic signed [15:0] last_err_reg, last_err_next;

    // Sequencer and working registers.
    logic [3:0]         state_reg, state_next;
    logic signed [15:0] err_reg, err_next;
    logic [15:0]        dt_reg, dt_next;
    logic signed [33:0] acc_sum_reg, acc_sum_next;
    logic signed [31:0] p_reg, p_next;
    logic [49:0]        sum_reg, sum_next;
    logic signed [15:0] res_drive_reg, res_drive_next;
    logic               res_sat_reg, res_sat_next;

    // Shift-add multiplier: the upper 34 bits accumulate, the lower 16 bits
    // start out as the serial operand and fill with product bits.
    logic [49:0]        mul_prod_reg, mul_prod_next;
    logic [32:0]        mul_cand_reg, mul_cand_next;
    logic [3:0]         mul_cnt_reg, mul_cnt_next;

    // Restoring divider, one quotient bit per cycle.
    logic [15:0]        div_rem_reg, div_rem_next;
    logic [46:0]        div_quo_reg, div_quo_next;
    logic [5:0]         div_cnt_reg, div_cnt_next;
    logic               div_busy_reg, div_busy_next;
    logic               div_neg_reg, div_neg_next;

    // Output register.
    logic               out_valid_reg, out_valid_next;
    result_item_t       out_item_reg, out_item_next;

    // Combinational helpers.
    logic [33:0]        mul_hi;
    logic [33:0]        mul_add;
    logic [33:0]        mul_sum;
    logic [49:0]        mul_step;
    logic [16:0]        div_r2;
    logic [16:0]        div_diff;
    logic               div_ge;
    logic [31:0]        dg_mag;
    logic [15:0]        mn_int;
    logic [15:0]        dt_eff;
    logic [16:0]        md_diff;
    logic signed [33:0] clp_lim;
    logic signed [33:0] clp_nlim;
    logic signed [41:0] rnd_val;
    logic signed [41:0] rnd_bound;
    logic signed [41:0] rnd_nbound;
    logic [49:0]        q_ext;
    logic               cfg_wr;
    reg_idx_t           cfg_idx;

    assign step_ready   = (state_reg == ST_IDLE);
    assign result_valid = out_valid_reg;
    assign result_data  = out_item_reg;
    assign pready       = 1'b1;

    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[4:2];

    // Read-back of the register file.
    always_comb
    begin
        unique case (cfg_idx)
            REG_GAIN_P:       prdata = {16'd0, gain_p_reg};
            REG_GAIN_I:       prdata = {16'd0, gain_i_reg};
            REG_GAIN_D:       prdata = {16'd0, gain_d_reg};
            REG_INT_BOUND:    prdata = {17'd0, int_bound_reg};
            REG_DRIVE_BOUND:  prdata = {17'd0, drv_bound_reg};
            REG_MIN_INTERVAL: prdata = {16'd0, min_int_reg};
            default:          prdata = '0;
        endcase
    end

    // One multiplier step. The serial operand is signed, so its top bit
    // carries negative weight and is subtracted on the last step.
    assign mul_hi   = mul_prod_reg[49:16];
    assign mul_add  = {mul_cand_reg[32], mul_cand_reg};
    assign mul_sum  = !mul_prod_reg[0] ? mul_hi :
                      (mul_cnt_reg == MUL_LAST) ? (mul_hi - mul_add) : (mul_hi + mul_add);
    assign mul_step = {mul_sum[33], mul_sum, mul_prod_reg[15:1]};

    // One divider step on the magnitude of the numerator.
    assign div_r2   = {div_rem_reg, div_quo_reg[46]};
    assign div_diff = div_r2 - {1'b0, dt_reg};
    assign div_ge   = (div_r2 >= {1'b0, dt_reg});

    // Magnitude of gain_d * (e - last_error); it stays below 2^31.
    assign dg_mag = mul_prod_reg[49] ? (32'd0 - mul_prod_reg[31:0]) : mul_prod_reg[31:0];

    // The interval is raised to the programmed minimum, and a zero minimum
    // behaves as one so the divisor is never zero.
    assign mn_int = (min_int_reg == 16'd0) ? 16'd1 : min_int_reg;
    assign dt_eff = (step_data.interval < mn_int) ? mn_int : step_data.interval;

    assign md_diff = {step_data.error_deg[15], step_data.error_deg}
                   - {last_err_reg[15], last_err_reg};

    assign clp_lim  = {3'b000, int_bound_reg, 16'h0000};
    assign clp_nlim = -clp_lim;

    // Drive after round-half-up to Q8.8, before saturation.
    assign rnd_val    = sum_reg[49:8];
    assign rnd_bound  = {27'd0, drv_bound_reg};
    assign rnd_nbound = -rnd_bound;

    assign q_ext = {3'b000, div_quo_reg};

    always_comb
    begin
        state_next     = state_reg;
        gain_p_next    = gain_p_reg;
        gain_i_next    = gain_i_reg;
        gain_d_next    = gain_d_reg;
        int_bound_next = int_bound_reg;
        drv_bound_next = drv_bound_reg;
        min_int_next   = min_int_reg;
        integral_next  = integral_reg;
        last_err_next  = last_err_reg;
        err_next       = err_reg;
        dt_next        = dt_reg;
        acc_sum_next   = acc_sum_reg;
        p_next         = p_reg;
        sum_next       = sum_reg;
        res_drive_next = res_drive_reg;
        res_sat_next   = res_sat_reg;
        mul_prod_next  = mul_prod_reg;
        mul_cand_next  = mul_cand_reg;
        mul_cnt_next   = mul_cnt_reg;
        div_rem_next   = div_rem_reg;
        div_quo_next   = div_quo_reg;
        div_cnt_next   = div_cnt_reg;
        div_busy_next  = div_busy_reg;
        div_neg_next   = div_neg_reg;
        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;

        if (out_valid_reg && result_ready)
        begin
            out_valid_next = 1'b0;
        end

        // The divider runs on its own once launched.
        if (div_busy_reg)
        begin
            div_rem_next = div_ge ? div_diff[15:0] : div_r2[15:0];
            div_quo_next = {div_quo_reg[45:0], div_ge};
            div_cnt_next = div_cnt_reg + 6'd1;
            if (div_cnt_reg == DIV_LAST)
            begin
                div_busy_next = 1'b0;
            end
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (step_valid)
                begin
                    err_next = step_data.error_deg;
                    dt_next  = dt_eff;
                    if (step_data.clear)
                    begin
                        integral_next  = '0;
                        last_err_next  = '0;
                        res_drive_next = '0;
                        res_sat_next   = 1'b0;
                        state_next     = ST_DONE;
                    end
                    else
                    begin
                        mul_prod_next = {34'd0, gain_d_reg};
                        mul_cand_next = {{16{md_diff[16]}}, md_diff};
                        mul_cnt_next  = '0;
                        state_next    = ST_MD;
                    end
                end
            end
            ST_MD:
            begin
                mul_prod_next = mul_step;
                mul_cnt_next  = mul_cnt_reg + 4'd1;
                if (mul_cnt_reg == MUL_LAST)
                begin
                    state_next = ST_DIVGO;
                end
            end
            ST_DIVGO:
            begin
                // The numerator carries a factor of 2^16, hence the zero fill.
                div_neg_next  = mul_prod_reg[49];
                div_quo_next  = {dg_mag[30:0], 16'd0};
                div_rem_next  = '0;
                div_cnt_next  = '0;
                div_busy_next = 1'b1;
                mul_prod_next = {34'd0, err_reg};
                mul_cand_next = {17'd0, dt_reg};
                mul_cnt_next  = '0;
                state_next    = ST_MED;
            end
            ST_MED:
            begin
                mul_prod_next = mul_step;
                mul_cnt_next  = mul_cnt_reg + 4'd1;
                if (mul_cnt_reg == MUL_LAST)
                begin
                    state_next = ST_ACC;
                end
            end
            ST_ACC:
            begin
                acc_sum_next = {{2{integral_reg[31]}}, integral_reg}
                             + {mul_prod_reg[32], mul_prod_reg[32:0]};
                state_next   = ST_CLAMP;
            end
            ST_CLAMP:
            begin
                if (acc_sum_reg > clp_lim)
                begin
                    integral_next = clp_lim[31:0];
                end
                else if (acc_sum_reg < clp_nlim)
                begin
                    integral_next = clp_nlim[31:0];
                end
                else
                begin
                    integral_next = acc_sum_reg[31:0];
                end
                mul_prod_next = {34'd0, gain_p_reg};
                mul_cand_next = {{17{err_reg[15]}}, err_reg};
                mul_cnt_next  = '0;
                state_next    = ST_MP;
            end
            ST_MP:
            begin
                mul_prod_next = mul_step;
                mul_cnt_next  = mul_cnt_reg + 4'd1;
                if (mul_cnt_reg == MUL_LAST)
                begin
                    state_next = ST_PSAVE;
                end
            end
            ST_PSAVE:
            begin
                p_next        = mul_prod_reg[31:0];
                mul_prod_next = {34'd0, gain_i_reg};
                mul_cand_next = {integral_reg[31], integral_reg};
                mul_cnt_next  = '0;
                state_next    = ST_MI;
            end
            ST_MI:
            begin
                mul_prod_next = mul_step;
                mul_cnt_next  = mul_cnt_reg + 4'd1;
                if (mul_cnt_reg == MUL_LAST)
                begin
                    state_next = ST_ISUM;
                end
            end
            ST_ISUM:
            begin
                // The integral term is the product floored by 2^16.
                sum_next   = {{18{p_reg[31]}}, p_reg}
                           + {{18{mul_prod_reg[47]}}, mul_prod_reg[47:16]}
                           + RND_HALF;
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                if (!div_busy_reg)
                begin
                    // Add the quotient, negated through inversion and carry-in
                    // when the numerator was negative.
                    sum_next   = sum_reg + (q_ext ^ {50{div_neg_reg}})
                               + {49'd0, div_neg_reg};
                    state_next = ST_RND;
                end
            end
            ST_RND:
            begin
                if (rnd_val > rnd_bound)
                begin
                    res_drive_next = rnd_bound[15:0];
                    res_sat_next   = 1'b1;
                end
                else if (rnd_val < rnd_nbound)
                begin
                    res_drive_next = rnd_nbound[15:0];
                    res_sat_next   = 1'b1;
                end
                else
                begin
                    res_drive_next = rnd_val[15:0];
                    res_sat_next   = 1'b0;
                end
                last_err_next = err_reg;
                state_next    = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || result_ready)
                begin
                    out_item_next.drive     = res_drive_reg;
                    out_item_next.saturated = res_sat_reg;
                    out_valid_next          = 1'b1;
                    state_next              = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Register writes must arrive only while the block is idle; the block itself
        // does not enforce this. A gain write restarts the controller history.
        if (cfg_wr)
        begin
            unique case (cfg_idx)
                REG_GAIN_P:
                begin
                    gain_p_next   = pwdata[15:0];
                    integral_next = '0;
                    last_err_next = '0;
                end
                REG_GAIN_I:
                begin
                    gain_i_next   = pwdata[15:0];
                    integral_next = '0;
                    last_err_next = '0;
                end
                REG_GAIN_D:
                begin
                    gain_d_next   = pwdata[15:0];
                    integral_next = '0;
                    last_err_next = '0;
                end
                REG_INT_BOUND:    int_bound_next = pwdata[14:0];
                REG_DRIVE_BOUND:  drv_bound_next = pwdata[14:0];
                REG_MIN_INTERVAL: min_int_next   = pwdata[15:0];
                default:
                begin
                end
            endcase
        end
    end

    // Control state, register file and controller history.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            gain_p_reg    <= GAIN_P_RST;
            gain_i_reg    <= GAIN_I_RST;
            gain_d_reg    <= GAIN_D_RST;
            int_bound_reg <= INT_BOUND_RST;
            drv_bound_reg <= DRIVE_BOUND_RST;
            min_int_reg   <= MIN_INTERVAL_RST;
            integral_reg  <= '0;
            last_err_reg  <= '0;
            mul_cnt_reg   <= '0;
            div_cnt_reg   <= '0;
            div_busy_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            gain_p_reg    <= gain_p_next;
            gain_i_reg    <= gain_i_next;
            gain_d_reg    <= gain_d_next;
            int_bound_reg <= int_bound_next;
            drv_bound_reg <= drv_bound_next;
            min_int_reg   <= min_int_next;
            integral_reg  <= integral_next;
            last_err_reg  <= last_err_next;
            mul_cnt_reg   <= mul_cnt_next;
            div_cnt_reg   <= div_cnt_next;
            div_busy_reg  <= div_busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        err_reg       <= err_next;
        dt_reg        <= dt_next;
        acc_sum_reg   <= acc_sum_next;
        p_reg         <= p_next;
        sum_reg       <= sum_next;
        res_drive_reg <= res_drive_next;
        res_sat_reg   <= res_sat_next;
        mul_prod_reg  <= mul_prod_next;
        mul_cand_reg  <= mul_cand_next;
        div_rem_reg   <= div_rem_next;
        div_quo_reg   <= div_quo_next;
        div_neg_reg   <= div_neg_next;
        out_item_reg  <= out_item_next;
    end

endmodule

`default_nettype wire

// ----- sv/pcc_checker.sv -----
// Port-level checks for the clamped PID controller and their binding.
`default_nettype none

module pcc_checker (
    input  wire                     clk,
    input  wire                     rst_n,
    input  wire                     step_valid,
    input  wire                     step_ready,
    input  wire                     result_valid,
    input  wire                     result_ready,
    input  pcc_pkg::result_item_t   result_data
);

    import pcc_pkg::*;

    // Items accepted whose results have not yet been delivered.
    logic [1:0] pend_reg, pend_next;

    always_comb
    begin
        pend_next = pend_reg;
        if (step_valid && step_ready && !(result_valid && result_ready))
        begin
            pend_next = pend_reg + 2'd1;
        end
        else if (!(step_valid && step_ready) && result_valid && result_ready)
        begin
            pend_next = pend_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    // The block works on one item at a time.
    a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
        (step_valid && step_ready) |=> !step_ready)
        else $error("step accepted while another item is in work");

    // When ready, at most one finished result may still be waiting.
    a_backlog: assert property (@(posedge clk) disable iff (!rst_n)
        step_ready |-> (pend_reg <= 2'd1))
        else $error("too many items outstanding");

    // A result is only offered for an item that was accepted.
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (pend_reg != 2'd0))
        else $error("result offered with no item outstanding");

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result_ready) |=> (result_valid && $stable(result_data)))
        else $error("stalled result changed or dropped");

endmodule

bind pid_controller_clamped_core pcc_checker u_pcc_checker (.*);

`default_nettype wire
